@@ rtl/core/hrrn_pkg.sv @@
// Shared types and constants for the HRRN ready-queue scheduler.
// No dependencies.
package hrrn_pkg;

    localparam int unsigned DEF_SLOTS = 16;

    localparam logic [1:0] REQ_ADMIT    = 2'd0;
    localparam logic [1:0] REQ_TICK     = 2'd1;
    localparam logic [1:0] REQ_DISPATCH = 2'd2;
    localparam logic [1:0] REQ_BURST    = 2'd3;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_HRRN = 1'b1;

    localparam logic [1:0] CFG_POLICY_MODE      = 2'd0;
    localparam logic [1:0] CFG_SMOOTHING_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_INITIAL_ESTIMATE = 2'd2;

    localparam logic [8:0]  RST_WEIGHT   = 9'd128;
    localparam logic [31:0] RST_INIT_EST = 32'd10000;
    localparam logic [8:0]  FULL_WEIGHT  = 9'd256;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  slot_id;
        logic        is_new;
        logic [31:0] elapsed_time;
        logic [31:0] burst_time;
        logic        exited;
    } req_t;

    typedef struct packed {
        logic        dispatch_valid;
        logic [3:0]  dispatched_slot;
        logic [31:0] new_estimate;
    } rsp_t;

    typedef struct packed {
        logic [31:0] wait_time;
        logic [31:0] estimate;
        logic [31:0] stamp;
    } entry_t;

endpackage

@@ rtl/core/hrrn_entry_ram.sv @@
// Per-slot entry store: wait time, estimate, admit stamp.
// Synchronous one-port-write, one-port-read RAM, registered read. Uses hrrn_pkg.
module hrrn_entry_ram
    import hrrn_pkg::*;
#(
    parameter int unsigned SLOTS = DEF_SLOTS,
    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data
);

    entry_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/hrrn_ready_queue_scheduler.sv @@
// HRRN ready-queue scheduler: one request in, one response out, per slot
// state in hrrn_entry_ram with ready/estimate-valid bits in flops. Uses hrrn_pkg.
//
// One request is worked at a time; the next is taken once the response has
// left the output register. Admit and burst-done each do one RAM read, then a
// write back; burst-done forms its two 9x32 products in turn and skips the
// write back when the process exited. Tick walks the slots through the single
// RAM read port, reading and writing back each ready slot and passing over each
// idle slot, then reads the addressed estimate. Dispatch walks the slots the
// same way with read, two 32x32 cross products and compare for each ready slot
// and a pass over each idle slot, then writes back the winner, if any. No
// clearing pass is needed after reset.
module hrrn_ready_queue_scheduler
    import hrrn_pkg::*;
#(
    parameter int unsigned SLOTS = DEF_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W:0] LAST_CNT = (IDX_W + 1)'(SLOTS);
    localparam logic [IDX_W:0] CNT_ONE  = (IDX_W + 1)'(1);
    localparam logic [8:0] SLOTS_W9 = 9'(SLOTS);

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_ADM_RD  = 14'b00000000000010,
        ST_ADM_WR  = 14'b00000000000100,
        ST_BST_RD  = 14'b00000000001000,
        ST_BST_M1  = 14'b00000000010000,
        ST_BST_M2  = 14'b00000000100000,
        ST_TK_RD   = 14'b00000001000000,
        ST_TK_WR   = 14'b00000010000000,
        ST_DSP_RD  = 14'b00000100000000,
        ST_DSP_M1  = 14'b00001000000000,
        ST_DSP_M2  = 14'b00010000000000,
        ST_DSP_CMP = 14'b00100000000000,
        ST_DSP_WR  = 14'b01000000000000,
        ST_EST_RD  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic        mode_reg, mode_next;
    logic [8:0]  weight_reg, weight_next;
    logic [31:0] init_est_reg, init_est_next;
    logic [31:0] counter_reg, counter_next;
    logic [SLOTS-1:0] ready_reg, ready_next;
    logic [SLOTS-1:0] est_ok_reg, est_ok_next;

    req_t        cur_reg, cur_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;
    logic [IDX_W:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic        found_reg, found_next;
    logic        est_pending_reg, est_pending_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    entry_t      best_reg, best_next;
    entry_t      cand_reg, cand_next;
    logic [63:0] lhs_reg, lhs_next;
    logic [63:0] rhs_reg, rhs_next;
    logic [40:0] prod_reg, prod_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic [IDX_W-1:0] slot_addr;
    logic [IDX_W-1:0] cnt_idx;
    logic             in_range;
    logic [31:0]      eff_est;
    logic [8:0]       alpha;
    logic [32:0]      tick_sum;
    logic [40:0]      blend;
    logic [31:0]      blend_est;
    logic [31:0]      adm_est;
    logic             win;

    hrrn_entry_ram #(.SLOTS(SLOTS)) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign req_ready = (state_reg == ST_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign slot_addr = IDX_W'(cur_reg.slot_id);
    assign cnt_idx   = cnt_reg[IDX_W-1:0];
    assign in_range  = {5'd0, cur_reg.slot_id} < SLOTS_W9;
    // never-written estimates read as one
    assign eff_est   = est_ok_reg[addr_reg] ? rd_data.estimate : 32'd1;
    assign alpha     = (weight_reg > FULL_WEIGHT) ? FULL_WEIGHT : weight_reg;
    assign tick_sum  = {1'b0, rd_data.wait_time} + {1'b0, cur_reg.elapsed_time};
    assign blend     = prod_reg + 41'((FULL_WEIGHT - alpha) * cand_reg.estimate);
    assign blend_est = (blend[39:8] == 32'd0) ? 32'd1 : blend[39:8];
    assign adm_est   = !cur_reg.is_new ? eff_est
                     : (init_est_reg == 32'd0) ? 32'd1 : init_est_reg;
    // equal ratios (or FIFO) fall back to the earlier stamp
    assign win = !found_reg
              || ((mode_reg == MODE_HRRN) && (lhs_reg != rhs_reg) ? (lhs_reg > rhs_reg)
                                                                   : (cand_reg.stamp < best_reg.stamp));

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        weight_next      = weight_reg;
        init_est_next    = init_est_reg;
        counter_next     = counter_reg;
        ready_next       = ready_reg;
        est_ok_next      = est_ok_reg;
        cur_next         = cur_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;
        cnt_next         = cnt_reg;
        addr_next        = addr_reg;
        found_next       = found_reg;
        est_pending_next = est_pending_reg;
        best_idx_next    = best_idx_reg;
        best_next        = best_reg;
        cand_next        = cand_reg;
        lhs_next         = lhs_reg;
        rhs_next         = rhs_reg;
        prod_next        = prod_reg;
        rd_en            = 1'b0;
        rd_addr          = addr_reg;
        wr_en            = 1'b0;
        wr_addr          = addr_reg;
        wr_data          = rd_data;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POLICY_MODE:      mode_next     = cfg_data[0];
                CFG_SMOOTHING_WEIGHT: weight_next   = cfg_data[8:0];
                CFG_INITIAL_ESTIMATE: init_est_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cur_next   = req;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    unique case (req.req_type)
                        REQ_ADMIT:    state_next = ST_ADM_RD;
                        REQ_TICK:     state_next = ST_TK_RD;
                        REQ_DISPATCH: state_next = ST_DSP_RD;
                        default:      state_next = ST_BST_RD;
                    endcase
                end
            end

            ST_ADM_RD, ST_BST_RD, ST_EST_RD:
            begin
                if (!in_range)
                begin
                    rsp_next       = '0;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (state_reg == ST_EST_RD && est_pending_reg)
                begin
                    est_pending_next = 1'b0;
                    rsp_next         = '0;
                    rsp_next.new_estimate = eff_est;
                    rsp_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = slot_addr;
                    addr_next = slot_addr;
                    unique case (state_reg)
                        ST_ADM_RD: state_next = ST_ADM_WR;
                        ST_BST_RD: state_next = ST_BST_M1;
                        default:   est_pending_next = 1'b1;
                    endcase
                end
            end

            ST_ADM_WR:
            begin
                wr_en   = 1'b1;
                wr_data = '{wait_time: 32'd0, estimate: adm_est, stamp: counter_reg};
                ready_next[addr_reg]  = 1'b1;
                est_ok_next[addr_reg] = 1'b1;
                counter_next   = counter_reg + 32'd1;
                rsp_next       = '0;
                rsp_next.new_estimate = adm_est;
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_BST_M1:
            begin
                cand_next = '{wait_time: rd_data.wait_time, estimate: eff_est,
                              stamp: rd_data.stamp};
                prod_next = 41'(alpha * cur_reg.burst_time);
                if (cur_reg.exited)
                begin
                    rsp_next       = '0;
                    rsp_next.new_estimate = eff_est;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_BST_M2;
                end
            end

            ST_BST_M2:
            begin
                wr_en   = 1'b1;
                wr_data = '{wait_time: cand_reg.wait_time, estimate: blend_est,
                            stamp: cand_reg.stamp};
                est_ok_next[addr_reg] = 1'b1;
                rsp_next       = '0;
                rsp_next.new_estimate = blend_est;
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_TK_RD:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    est_pending_next = 1'b0;
                    state_next       = ST_EST_RD;
                end
                else if (!ready_reg[cnt_idx])
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cnt_idx;
                    addr_next  = cnt_idx;
                    state_next = ST_TK_WR;
                end
            end

            ST_TK_WR:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                wr_data.wait_time = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
                cnt_next   = cnt_reg + CNT_ONE;
                state_next = ST_TK_RD;
            end

            ST_DSP_RD:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    if (found_reg)
                    begin
                        state_next = ST_DSP_WR;
                    end
                    else
                    begin
                        rsp_next       = '0;
                        rsp_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (!ready_reg[cnt_idx])
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cnt_idx;
                    addr_next  = cnt_idx;
                    state_next = ST_DSP_M1;
                end
            end

            ST_DSP_M1:
            begin
                cand_next = '{wait_time: rd_data.wait_time, estimate: eff_est,
                              stamp: rd_data.stamp};
                lhs_next   = 64'(rd_data.wait_time) * 64'(best_reg.estimate);
                state_next = ST_DSP_M2;
            end

            ST_DSP_M2:
            begin
                rhs_next   = 64'(best_reg.wait_time) * 64'(cand_reg.estimate);
                state_next = ST_DSP_CMP;
            end

            ST_DSP_CMP:
            begin
                if (win)
                begin
                    best_next     = cand_reg;
                    best_idx_next = addr_reg;
                    found_next    = 1'b1;
                end
                cnt_next   = cnt_reg + CNT_ONE;
                state_next = ST_DSP_RD;
            end

            ST_DSP_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = best_idx_reg;
                wr_data = '{wait_time: 32'd0, estimate: best_reg.estimate,
                            stamp: best_reg.stamp};
                ready_next[best_idx_reg] = 1'b0;
                rsp_next.dispatch_valid  = 1'b1;
                rsp_next.dispatched_slot = 4'(best_idx_reg);
                rsp_next.new_estimate    = best_reg.estimate;
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_FIFO;
            weight_reg      <= RST_WEIGHT;
            init_est_reg    <= RST_INIT_EST;
            counter_reg     <= '0;
            ready_reg       <= '0;
            est_ok_reg      <= '0;
            rsp_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            found_reg       <= 1'b0;
            est_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            weight_reg      <= weight_next;
            init_est_reg    <= init_est_next;
            counter_reg     <= counter_next;
            ready_reg       <= ready_next;
            est_ok_reg      <= est_ok_next;
            rsp_valid_reg   <= rsp_valid_next;
            cnt_reg         <= cnt_next;
            found_reg       <= found_next;
            est_pending_reg <= est_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        rsp_reg      <= rsp_next;
        addr_reg     <= addr_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        cand_reg     <= cand_next;
        lhs_reg      <= lhs_next;
        rhs_reg      <= rhs_next;
        prod_reg     <= prod_next;
    end

endmodule

@@ rtl/core/hrrn_chk.sv @@
// Port-level checks for hrrn_ready_queue_scheduler, bound to the top level.
// Uses hrrn_pkg.
module hrrn_chk
    import hrrn_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // a held response must not change
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // every accepted request leaves the scheduler busy
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_empty_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.dispatch_valid |-> rsp.dispatched_slot == 4'd0)
        else $error("slot reported without dispatch");

    a_dispatch_est: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.dispatch_valid |-> rsp.new_estimate != 32'd0)
        else $error("dispatched slot has zero estimate");

endmodule

bind hrrn_ready_queue_scheduler hrrn_chk u_hrrn_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

@@ tb/hrrn_ready_queue_scheduler_test.sv @@
// Self-checking testbench for the HRRN ready-queue scheduler.
// Drives a directed table and then random requests, and checks every response
// against a behavioral scheduler model. Depends on hrrn_pkg and the RTL top level.
module hrrn_ready_queue_scheduler_test;
    import hrrn_pkg::*;

    localparam int NSLOT = 16;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    hrrn_ready_queue_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scheduler model state
    logic        mdl_mode;
    logic [8:0]  mdl_weight;
    logic [31:0] mdl_init_est;
    logic        mdl_ready [NSLOT];
    logic [31:0] mdl_wait [NSLOT];
    logic [31:0] mdl_est [NSLOT];
    logic [31:0] mdl_stamp [NSLOT];
    logic [31:0] mdl_counter;

    rsp_t rsp_pending [$];
    int   n_errors;
    int   hold_cycles;
    bit   rand_idle;
    bit   sending_done;

    // directed table: request plus an optional typed-in response
    typedef struct {
        req_t r;
        bit   has_exp;
        rsp_t e;
    } dir_row_t;

    dir_row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("hrrn_ready_queue_scheduler test failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic bit slot_wins(int a, int b);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = 64'(mdl_wait[a]) * 64'(mdl_est[b]);
        rhs = 64'(mdl_wait[b]) * 64'(mdl_est[a]);
        if (mdl_mode == MODE_HRRN && lhs != rhs)
            return lhs > rhs;
        return mdl_stamp[a] < mdl_stamp[b];
    endfunction

    function automatic rsp_t schedule_step(req_t q);
        rsp_t        o;
        logic [32:0] w;
        logic [8:0]  a;
        logic [63:0] n;
        bit          found;
        int          best;
        o = '0;
        found = 0;
        best = 0;
        case (q.req_type)
            REQ_ADMIT:
            begin
                mdl_ready[q.slot_id] = 1'b1;
                mdl_wait[q.slot_id] = '0;
                mdl_stamp[q.slot_id] = mdl_counter;
                mdl_counter = mdl_counter + 1;
                if (q.is_new)
                    mdl_est[q.slot_id] = (mdl_init_est == 0) ? 32'd1 : mdl_init_est;
                o.new_estimate = mdl_est[q.slot_id];
            end
            REQ_TICK:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (mdl_ready[i])
                    begin
                        w = {1'b0, mdl_wait[i]} + {1'b0, q.elapsed_time};
                        mdl_wait[i] = w[32] ? 32'hFFFF_FFFF : w[31:0];
                    end
                o.new_estimate = mdl_est[q.slot_id];
            end
            REQ_DISPATCH:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (mdl_ready[i] && (!found || slot_wins(i, best)))
                    begin
                        best = i;
                        found = 1;
                    end
                if (found)
                begin
                    mdl_ready[best] = 1'b0;
                    mdl_wait[best] = '0;
                    o.dispatch_valid = 1'b1;
                    o.dispatched_slot = best[3:0];
                    o.new_estimate = mdl_est[best];
                end
            end
            default:
            begin
                if (!q.exited)
                begin
                    a = (mdl_weight > FULL_WEIGHT) ? FULL_WEIGHT : mdl_weight;
                    n = (64'(a) * 64'(q.burst_time)
                         + 64'(FULL_WEIGHT - a) * 64'(mdl_est[q.slot_id])) >> 8;
                    if (n > 64'hFFFF_FFFF)
                        n = 64'hFFFF_FFFF;
                    if (n == 0)
                        n = 1;
                    mdl_est[q.slot_id] = n[31:0];
                end
                o.new_estimate = mdl_est[q.slot_id];
            end
        endcase
        return o;
    endfunction

    function automatic req_t make_req(logic [1:0] t, logic [3:0] s, logic nw,
                                      logic [31:0] el, logic [31:0] bu, logic ex);
        req_t q;
        q.req_type = t;
        q.slot_id = s;
        q.is_new = nw;
        q.elapsed_time = el;
        q.burst_time = bu;
        q.exited = ex;
        return q;
    endfunction

    function automatic rsp_t make_rsp(logic v, logic [3:0] s, logic [31:0] e);
        rsp_t o;
        o.dispatch_valid = v;
        o.dispatched_slot = s;
        o.new_estimate = e;
        return o;
    endfunction

    task automatic add_row(req_t q, bit he, rsp_t e);
        dir_row_t row;
        row.r = q;
        row.has_exp = he;
        row.e = e;
        dir_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_POLICY_MODE:      mdl_mode = val[0];
            CFG_SMOOTHING_WEIGHT: mdl_weight = val[8:0];
            default:              mdl_init_est = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one transfer on the request channel; model runs at acceptance
    task automatic send_req(input req_t q, input bit he, input rsp_t e);
        rsp_t p;
        @(negedge clk);
        while (rand_idle && $urandom_range(99) < 10)
            @(negedge clk);
        req_valid <= 1'b1;
        req <= q;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        p = schedule_step(q);
        if (he && p !== e)
            report_mismatch("directed row", p.new_estimate, e.new_estimate);
        rsp_pending.push_back(p);
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (rsp_pending.size() != 0)
            @(posedge clk);
        repeat (2 * NSLOT * 4 + 10)
            @(posedge clk);
    endtask

    // receiver side
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= !(rand_idle && $urandom_range(99) < 10);
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_pending.size() == 0)
                report_mismatch("unexpected response", rsp.new_estimate, 32'h0);
            else
            begin
                want = rsp_pending.pop_front();
                if (rsp.dispatch_valid !== want.dispatch_valid)
                    report_mismatch("dispatch_valid", 32'(rsp.dispatch_valid),
                                    32'(want.dispatch_valid));
                if (rsp.dispatched_slot !== want.dispatched_slot)
                    report_mismatch("dispatched_slot", 32'(rsp.dispatched_slot),
                                    32'(want.dispatched_slot));
                if (rsp.new_estimate !== want.new_estimate)
                    report_mismatch("new_estimate", rsp.new_estimate, want.new_estimate);
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1000);
            3: return $urandom_range(100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t rand_req();
        int          k;
        logic [1:0]  t;
        k = $urandom_range(99);
        if (k < 35)
            t = REQ_ADMIT;
        else if (k < 55)
            t = REQ_TICK;
        else if (k < 80)
            t = REQ_DISPATCH;
        else
            t = REQ_BURST;
        return make_req(t, 4'($urandom_range(15)), 1'($urandom_range(1)), rand_word(),
                        rand_word(), 1'($urandom_range(3) == 0));
    endfunction

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POLICY_MODE;
        cfg_data = '0;
        n_errors = 0;
        hold_cycles = 0;
        rand_idle = 1'b0;
        sending_done = 1'b0;
        mdl_mode = MODE_FIFO;
        mdl_weight = RST_WEIGHT;
        mdl_init_est = RST_INIT_EST;
        mdl_counter = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            mdl_ready[i] = 1'b0;
            mdl_wait[i] = '0;
            mdl_est[i] = 32'd1;
            mdl_stamp[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset state, empty dispatch, extremes, FIFO policy
        add_row(make_req(REQ_DISPATCH, 4'd0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0));
        add_row(make_req(REQ_TICK, 4'd15, 0, 32'hFFFF_FFFF, 0, 0), 1, make_rsp(0, 0, 1));
        add_row(make_req(REQ_BURST, 4'd3, 0, 0, 0, 1), 1, make_rsp(0, 0, 1));
        add_row(make_req(REQ_BURST, 4'd3, 0, 0, 0, 0), 1, make_rsp(0, 0, 1));
        add_row(make_req(REQ_ADMIT, 4'd0, 1, 0, 0, 0), 1, make_rsp(0, 0, 10000));
        add_row(make_req(REQ_ADMIT, 4'd15, 0, 0, 0, 0), 1, make_rsp(0, 0, 1));
        add_row(make_req(REQ_ADMIT, 4'd7, 1, 0, 0, 0), 0, '0);
        add_row(make_req(REQ_TICK, 4'd7, 0, 32'hFFFF_FFFF, 0, 0), 0, '0);
        add_row(make_req(REQ_TICK, 4'd0, 0, 32'd5, 0, 0), 0, '0);
        add_row(make_req(REQ_ADMIT, 4'd0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(REQ_DISPATCH, 4'd0, 0, 0, 0, 0), 1, make_rsp(1, 15, 1));
        add_row(make_req(REQ_BURST, 4'd7, 0, 0, 32'hFFFF_FFFF, 0), 0, '0);
        add_row(make_req(REQ_BURST, 4'd7, 0, 0, 32'd0, 0), 0, '0);
        add_row(make_req(REQ_DISPATCH, 4'd0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(REQ_DISPATCH, 4'd0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(REQ_DISPATCH, 4'd0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0));
        foreach (dir_rows[i])
            send_req(dir_rows[i].r, dir_rows[i].has_exp, dir_rows[i].e);
        drain_results();

        // HRRN with full weight, zero initial estimate clamps to one
        write_reg(CFG_POLICY_MODE, 32'(MODE_HRRN));
        write_reg(CFG_SMOOTHING_WEIGHT, 32'(FULL_WEIGHT));
        write_reg(CFG_INITIAL_ESTIMATE, 32'd0);
        for (int i = 0; i < 6; i++)
            send_req(make_req(REQ_ADMIT, 4'(i), 1, 0, 0, 0), 0, '0);
        send_req(make_req(REQ_BURST, 4'd2, 0, 0, 32'd50, 0), 0, '0);
        send_req(make_req(REQ_TICK, 4'd2, 0, 32'd100, 0, 0), 0, '0);
        for (int i = 0; i < 7; i++)
            send_req(make_req(REQ_DISPATCH, 4'd0, 0, 0, 0, 0), 0, '0);
        drain_results();

        rand_idle = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_SMOOTHING_WEIGHT, 32'd511);
                         write_reg(CFG_INITIAL_ESTIMATE, 32'hFFFF_FFFF); end
                1: begin write_reg(CFG_POLICY_MODE, 32'(MODE_FIFO));
                         write_reg(CFG_SMOOTHING_WEIGHT, 32'd0); end
                2: begin write_reg(CFG_POLICY_MODE, 32'(MODE_HRRN));
                         write_reg(CFG_INITIAL_ESTIMATE, 32'd1); end
                default:
                begin
                    write_reg(CFG_POLICY_MODE, $urandom_range(1));
                    write_reg(CFG_SMOOTHING_WEIGHT, $urandom_range(300));
                    write_reg(CFG_INITIAL_ESTIMATE, rand_word());
                end
            endcase
            // phase 3: no idling on either side; phase 4: long receiver hold-off
            rand_idle = (ph != 3);
            if (ph == 4)
                hold_cycles = 400;
            for (int n = 0; n < 150; n++)
                send_req(rand_req(), 0, '0);
            drain_results();
        end
        sending_done = 1'b1;

        if (n_errors == 0 && rsp_pending.size() == 0)
            $display("hrrn_ready_queue_scheduler test passed");
        else
            $display("hrrn_ready_queue_scheduler test failed");
        $finish;
    end
endmodule
